// ===== src/essc_pkg.sv =====
// essc_pkg: shared constants, types and the control store of the speed control core
`default_nettype none

package essc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd1;
    localparam logic [2:0] REG_MIN     = 3'd2;
    localparam logic [2:0] REG_MAX     = 3'd3;
    localparam logic [2:0] REG_STEPS   = 3'd4;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // configuration reset values
    localparam logic [15:0] RST_TIMEOUT = 16'd300;
    localparam logic [7:0]  RST_COUNT   = 8'd5;
    localparam logic [7:0]  RST_MIN     = 8'd1;
    localparam logic [7:0]  RST_MAX     = 8'd50;
    localparam logic [14:0] RST_STEPS   = 15'd3200;
    localparam logic [7:0]  RST_SPEED   = 8'd30;

    // fast-turn step thresholds and sizes
    localparam logic [7:0] FAST_HI_RPM  = 8'd20;
    localparam logic [7:0] FAST_MID_RPM = 8'd10;
    localparam logic [2:0] STEP_BIG     = 3'd5;
    localparam logic [2:0] STEP_MID     = 3'd2;
    localparam logic [2:0] STEP_ONE     = 3'd1;

    // period divider: microseconds per minute over twice the step rate
    localparam int QUO_W = 26;
    localparam int DVS_W = 24;
    localparam int HP_W  = 18;
    localparam logic [QUO_W-1:0] US_PER_MIN = 26'd60000000;
    localparam logic [HP_W-1:0]  HP_MAX     = 18'h3FFFF;
    localparam logic [4:0]       DIV_LAST   = 5'(QUO_W - 1);

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LATCH = 3'd1;
    localparam logic [2:0] OP_QUAL  = 3'd2;
    localparam logic [2:0] OP_SPEED = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_OUT   = 3'd6;

    // jump conditions
    localparam logic [2:0] JC_NEVER    = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_VALID = 3'd2;
    localparam logic [2:0] JC_DIR_ZERO = 3'd3;
    localparam logic [2:0] JC_HELD     = 3'd4;
    localparam logic [2:0] JC_DIV_MORE = 3'd5;
    localparam logic [2:0] JC_OUT_BUSY = 3'd6;

    // program addresses
    localparam logic [2:0] ST_WAIT  = 3'd0;
    localparam logic [2:0] ST_TZERO = 3'd1;
    localparam logic [2:0] ST_THELD = 3'd2;
    localparam logic [2:0] ST_QUAL  = 3'd3;
    localparam logic [2:0] ST_SPEED = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        logic [2:0] target;
    } ucode_t;

    // control store
    function automatic ucode_t ucode_rom(input logic [2:0] addr);
        ucode_t w;
        unique case (addr)
            ST_WAIT:  w = '{op: OP_LATCH, cond: JC_NO_VALID, target: ST_WAIT};
            ST_TZERO: w = '{op: OP_NONE,  cond: JC_DIR_ZERO, target: ST_MUL};
            ST_THELD: w = '{op: OP_NONE,  cond: JC_HELD,     target: ST_SPEED};
            ST_QUAL:  w = '{op: OP_QUAL,  cond: JC_ALWAYS,   target: ST_MUL};
            ST_SPEED: w = '{op: OP_SPEED, cond: JC_NEVER,    target: ST_WAIT};
            ST_MUL:   w = '{op: OP_MUL,   cond: JC_NEVER,    target: ST_WAIT};
            ST_DIV:   w = '{op: OP_DIV,   cond: JC_DIV_MORE, target: ST_DIV};
            ST_OUT:   w = '{op: OP_OUT,   cond: JC_ALWAYS,   target: ST_WAIT};
            default:  w = '{op: OP_NONE,  cond: JC_ALWAYS,   target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/encoder_stepper_speed_control_core.sv =====
// encoder_stepper_speed_control_core: microcoded speed, run and direction control
//
//   channel  signals                                          direction
//   in       in_valid/in_ready, turn_dir, button_held,        to core
//            fast_turn, time_ms
//   out      out_valid/out_ready, speed_rpm, half_period_us,  from core
//            motor_on, motor_reverse, display_dirty
//   cfg      cfg_we, cfg_index, cfg_data                      to core
//
// from accept to result, a zero turn goes straight to the divisor setup, and a held
// or counted turn first adjusts the speed or runs the qualifier; then the bit-serial
// restoring divider forms the half-period
// one word at a time: in_ready is high only in the wait step of the program
// a result waits in the output register; the next word is accepted meanwhile
// and its output step holds until the register is taken
// reset restores the configuration defaults, speed 30, motor stopped
`default_nettype none

module encoder_stepper_speed_control_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [essc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [essc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [1:0]                     turn_dir,
    input  wire logic                                  button_held,
    input  wire logic                                  fast_turn,
    input  wire logic [31:0]                           time_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [7:0]                                 speed_rpm,
    output logic [essc_pkg::HP_W-1:0]                  half_period_us,
    output logic                                       motor_on,
    output logic                                       motor_reverse,
    output logic                                       display_dirty
);

    // configuration registers
    logic [15:0] timeout_reg;
    logic [7:0]  count_reg;
    logic [7:0]  min_reg;
    logic [7:0]  max_reg;
    logic [14:0] steps_reg;

    // sequencer
    logic [2:0]        step_reg, step_next;
    essc_pkg::ucode_t  uw;
    logic              jump;

    // latched input word
    logic [1:0]  dir_reg;
    logic        held_reg;
    logic        fast_reg;
    logic [31:0] now_reg;

    // control state
    logic [7:0]  speed_reg, speed_next;
    logic        run_reg, run_next;
    logic        rev_reg, rev_next;
    logic [7:0]  qcnt_reg, qcnt_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        dirty_reg, dirty_next;

    // divider
    logic [essc_pkg::DVS_W-1:0] dvs_reg;
    logic [essc_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [essc_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]                 dcnt_reg, dcnt_next;

    // output register
    logic                       ovalid_reg;
    logic [7:0]                 ospeed_reg;
    logic [essc_pkg::HP_W-1:0]  ohp_reg;
    logic                       oon_reg;
    logic                       orev_reg;
    logic                       odirty_reg;

    logic out_busy;
    logic do_latch;
    logic do_out;

    // qualifier terms
    logic [31:0] elapsed;
    logic        late;
    logic [7:0]  qcnt_inc;
    logic        qfire;
    logic        backward;

    // speed adjust terms
    logic [2:0]        stepmag;
    logic signed [9:0] spd_s;
    logic signed [9:0] nv;
    logic signed [9:0] min_s;
    logic signed [9:0] max_s;
    logic [7:0]        spd_clamped;

    // divisor and division step terms
    logic [7:0]                 s_eff;
    logic [14:0]                st_eff;
    logic [22:0]                prod;
    logic [essc_pkg::DVS_W:0]   rem_sh;
    logic                       rem_ge;

    // control word fetch and jump decision
    assign uw       = essc_pkg::ucode_rom(step_reg);
    assign out_busy = ovalid_reg && !out_ready;
    assign backward = dir_reg[1];

    always_comb
    begin
        unique case (uw.cond)
            essc_pkg::JC_NEVER:    jump = 1'b0;
            essc_pkg::JC_ALWAYS:   jump = 1'b1;
            essc_pkg::JC_NO_VALID: jump = !in_valid;
            essc_pkg::JC_DIR_ZERO: jump = (dir_reg == 2'b00);
            essc_pkg::JC_HELD:     jump = held_reg;
            essc_pkg::JC_DIV_MORE: jump = (dcnt_reg != 5'd0);
            essc_pkg::JC_OUT_BUSY: jump = out_busy;
            default:               jump = 1'b1;
        endcase
    end

    // step counter; the output step also waits for a free output register
    always_comb
    begin
        if (uw.op == essc_pkg::OP_OUT && out_busy)
            step_next = step_reg;
        else if (jump)
            step_next = uw.target;
        else
            step_next = step_reg + 3'd1;
    end

    assign in_ready = (uw.op == essc_pkg::OP_LATCH);
    assign do_latch = in_ready && in_valid;
    assign do_out   = (uw.op == essc_pkg::OP_OUT) && !out_busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= essc_pkg::RST_TIMEOUT;
            count_reg   <= essc_pkg::RST_COUNT;
            min_reg     <= essc_pkg::RST_MIN;
            max_reg     <= essc_pkg::RST_MAX;
            steps_reg   <= essc_pkg::RST_STEPS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                essc_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                essc_pkg::REG_COUNT:   count_reg   <= cfg_data[7:0];
                essc_pkg::REG_MIN:     min_reg     <= cfg_data[7:0];
                essc_pkg::REG_MAX:     max_reg     <= cfg_data[7:0];
                essc_pkg::REG_STEPS:   steps_reg   <= cfg_data[14:0];
                default:               ;
            endcase
        end
    end

    // qualifier: count turns that follow each other within the window
    assign elapsed  = now_reg - stamp_reg;
    assign late     = elapsed > {16'd0, timeout_reg};
    assign qcnt_inc = qcnt_reg + 8'd1;
    assign qfire    = (qcnt_reg != 8'd0) && !late && (qcnt_inc >= count_reg);

    // held-button speed step and clamp, lower bound first
    always_comb
    begin
        if (!fast_reg)
            stepmag = essc_pkg::STEP_ONE;
        else if (speed_reg >= essc_pkg::FAST_HI_RPM)
            stepmag = essc_pkg::STEP_BIG;
        else if (speed_reg > essc_pkg::FAST_MID_RPM)
            stepmag = essc_pkg::STEP_MID;
        else
            stepmag = essc_pkg::STEP_ONE;
    end

    assign spd_s = $signed({2'b00, speed_reg});
    assign min_s = $signed({2'b00, min_reg});
    assign max_s = $signed({2'b00, max_reg});
    assign nv    = backward ? spd_s - $signed({7'd0, stepmag})
                            : spd_s + $signed({7'd0, stepmag});

    always_comb
    begin
        if (nv < min_s)
            spd_clamped = min_reg;
        else if (nv > max_s)
            spd_clamped = max_reg;
        else
            spd_clamped = nv[7:0];
    end

    // divisor: twice speed times steps, zero taken as one
    assign s_eff  = (speed_reg == 8'd0) ? 8'd1 : speed_reg;
    assign st_eff = (steps_reg == 15'd0) ? 15'd1 : steps_reg;
    assign prod   = s_eff * st_eff;

    // one restoring division step
    assign rem_sh = {rem_reg, quo_reg[essc_pkg::QUO_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dvs_reg};

    // datapath next values
    always_comb
    begin
        speed_next = speed_reg;
        run_next   = run_reg;
        rev_next   = rev_reg;
        qcnt_next  = qcnt_reg;
        stamp_next = stamp_reg;
        dirty_next = dirty_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        case (uw.op)
            essc_pkg::OP_LATCH:
            begin
                if (in_valid)
                    dirty_next = 1'b0;
            end
            essc_pkg::OP_QUAL:
            begin
                if (qcnt_reg == 8'd0 && !late)
                begin
                    stamp_next = now_reg;
                end
                else if (late)
                begin
                    qcnt_next  = 8'd1;
                    stamp_next = now_reg;
                end
                else if (qfire)
                begin
                    qcnt_next  = 8'd0;
                    stamp_next = now_reg;
                end
                else
                begin
                    qcnt_next = qcnt_inc;
                end
                if (qfire)
                begin
                    dirty_next = 1'b1;
                    if (run_reg)
                    begin
                        if (backward)
                            run_next = 1'b0;
                        else
                            rev_next = !rev_reg;
                    end
                    else
                    begin
                        run_next = 1'b1;
                        rev_next = backward;
                    end
                end
            end
            essc_pkg::OP_SPEED:
            begin
                speed_next = spd_clamped;
                dirty_next = 1'b1;
            end
            essc_pkg::OP_MUL:
            begin
                rem_next  = '0;
                quo_next  = essc_pkg::US_PER_MIN;
                dcnt_next = essc_pkg::DIV_LAST;
            end
            essc_pkg::OP_DIV:
            begin
                rem_next  = rem_ge ? rem_sh[essc_pkg::DVS_W-1:0] - dvs_reg
                                   : rem_sh[essc_pkg::DVS_W-1:0];
                quo_next  = {quo_reg[essc_pkg::QUO_W-2:0], rem_ge};
                dcnt_next = dcnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= essc_pkg::ST_WAIT;
            speed_reg  <= essc_pkg::RST_SPEED;
            run_reg    <= 1'b0;
            rev_reg    <= 1'b0;
            qcnt_reg   <= 8'd0;
            stamp_reg  <= 32'd0;
            dirty_reg  <= 1'b0;
            dcnt_reg   <= 5'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            speed_reg <= speed_next;
            run_reg   <= run_next;
            rev_reg   <= rev_next;
            qcnt_reg  <= qcnt_next;
            stamp_reg <= stamp_next;
            dirty_reg <= dirty_next;
            dcnt_reg  <= dcnt_next;
            if (do_out)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (do_latch)
        begin
            dir_reg  <= turn_dir;
            held_reg <= button_held;
            fast_reg <= fast_turn;
            now_reg  <= time_ms;
        end
        if (uw.op == essc_pkg::OP_MUL)
            dvs_reg <= {prod, 1'b0};
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (do_out)
        begin
            ospeed_reg <= speed_reg;
            ohp_reg    <= (quo_reg > essc_pkg::QUO_W'(essc_pkg::HP_MAX))
                          ? essc_pkg::HP_MAX : quo_reg[essc_pkg::HP_W-1:0];
            oon_reg    <= run_reg;
            orev_reg   <= rev_reg;
            odirty_reg <= dirty_reg;
        end
    end

    assign out_valid      = ovalid_reg;
    assign speed_rpm      = ospeed_reg;
    assign half_period_us = ohp_reg;
    assign motor_on       = oon_reg;
    assign motor_reverse  = orev_reg;
    assign display_dirty  = odirty_reg;

    // checks
    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == essc_pkg::ST_TZERO))
        else $error("accepted word did not start the program");

    a_div_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == essc_pkg::ST_DIV) |-> (dcnt_reg <= essc_pkg::DIV_LAST))
        else $error("divider bit count out of range");

    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> ($past(step_reg) == essc_pkg::ST_OUT))
        else $error("result raised outside the output step");

    a_div_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == essc_pkg::ST_MUL) |=> (step_reg == essc_pkg::ST_DIV))
        else $error("divider did not follow divisor setup");

endmodule

`default_nettype wire
